// ----- rtl/tsht_pkg.sv -----
// Shared types, codes and hash helpers of the tombstone hash table.
package tsht_pkg;

  localparam int unsigned SlotCountDef  = 1024;
  localparam int unsigned ValueBitsDef  = 32;
  localparam int unsigned KeyBits       = 32;
  localparam int unsigned CountBits     = 11;
  localparam logic [CountBits-1:0] MaxEntriesReset = 11'd716;

  localparam logic [31:0] HashMulA = 32'h85eb_ca6b;
  localparam logic [31:0] HashMulB = 32'hc2b2_ae35;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_KILL   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_NOT_FOUND = 3'd1,
    STATUS_DUPLICATE = 3'd2,
    STATUS_FULL      = 3'd3,
    STATUS_NO_ACTIVE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    MARK_ABSENT = 2'd0,
    MARK_ACTIVE = 2'd1,
    MARK_TOMB   = 2'd2
  } mark_e;

  // One xor-shift step of the murmur3 finalizer.
  function automatic logic [31:0] xorshift(input logic [31:0] x, input int unsigned sh);
    xorshift = x ^ (x >> sh);
  endfunction

endpackage

// ----- rtl/tsht_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module tsht_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tombstone_hash_table_unit.sv -----
// Top level of the tombstone hash table: hash pipeline, probe sequencer and slot memories.
//
//   channel   | signals                                   | flow control
//   ----------+-------------------------------------------+------------------------------
//   command   | start, busy, kind_i, key_i, value_in_i    | taken when start and !busy
//   result    | done_o, status_o, found_state_o, value_out_o | one-cycle strobe, no stall
//   config    | cfg_valid_i, cfg_ready_o, cfg_data_i      | valid/ready, max_entries
//
// A command runs through the states HASH1, HASH2 and HASH3 and then probes P slots, P being
// from 1 to SLOT_COUNT; the probe loop reads one slot per cycle from the slot memories. An
// insert refused by the occupancy limit, and an unused kind, end in HASH1. The result strobe
// comes in the cycle after the last probe (or after HASH1), when busy is already low. After
// reset a clearing pass marks every slot absent, with busy high.
module tombstone_hash_table_unit
  import tsht_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SlotCountDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           kind_i,
  input  logic [31:0]          key_i,
  input  logic [31:0]          value_in_i,
  output logic                 done_o,
  output logic [2:0]           status_o,
  output logic [1:0]           found_state_o,
  output logic [31:0]          value_out_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CountBits-1:0] cfg_data_i
);

  localparam int unsigned SlotBits = $clog2(SLOT_COUNT);
  localparam int unsigned DataBits = KeyBits + VALUE_BITS;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HASH1 = 6'b000100,
    S_HASH2 = 6'b001000,
    S_HASH3 = 6'b010000,
    S_PROBE = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  kind_e                 kind_q;
  logic [KeyBits-1:0]    key_q;
  logic [31:0]           value_q;
  logic [31:0]           hash_q, hash_d;
  logic [SlotBits-1:0]   idx_q, idx_d;
  logic [SlotBits-1:0]   probe_cnt_q, probe_cnt_d;
  logic [CountBits-1:0]  occ_q, occ_d;
  logic [CountBits-1:0]  max_entries_q;
  logic                  done_q, done_d;
  status_e               status_q, status_d;
  logic [1:0]            found_q, found_d;
  logic [31:0]           vout_q, vout_d;

  logic                  rd_en;
  logic [SlotBits-1:0]   rd_addr;
  logic [31:0]           hash_fin;
  logic [SlotBits-1:0]   home_idx;
  logic                  mark_we;
  logic [1:0]            mark_wdata;
  logic [1:0]            mark_rdata;
  mark_e                 mark_rd;
  logic                  data_we;
  logic                  data_zero_val;
  logic [DataBits-1:0]   data_wdata;
  logic [DataBits-1:0]   data_rdata;
  logic [KeyBits-1:0]    key_rd;
  logic [VALUE_BITS-1:0] val_rd;
  logic [VALUE_BITS-1:0] val_wr;
  logic [31:0]           val_rd32;
  logic                  key_hit;
  logic                  last_probe;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign hash_fin   = xorshift(hash_q, 16);
  assign home_idx   = hash_fin[SlotBits-1:0];
  assign mark_rd    = mark_e'(mark_rdata);
  assign key_rd     = data_rdata[DataBits-1:VALUE_BITS];
  assign val_rd     = data_rdata[VALUE_BITS-1:0];
  assign key_hit    = (key_rd == key_q);
  assign last_probe = &probe_cnt_q;

  // Values are kept to VALUE_BITS in the slot memory and shown as 32 bits.
  if (VALUE_BITS <= 32) begin : g_val_narrow
    assign val_wr   = value_q[VALUE_BITS-1:0];
    assign val_rd32 = 32'(val_rd);
  end else begin : g_val_wide
    assign val_wr   = VALUE_BITS'(value_q);
    assign val_rd32 = val_rd[31:0];
  end

  assign data_wdata = {key_q, (data_zero_val ? {VALUE_BITS{1'b0}} : val_wr)};

  always_comb begin
    state_d       = state_q;
    hash_d        = hash_q;
    idx_d         = idx_q;
    probe_cnt_d   = probe_cnt_q;
    occ_d         = occ_q;
    done_d        = 1'b0;
    status_d      = status_q;
    found_d       = found_q;
    vout_d        = vout_q;
    rd_en         = 1'b0;
    rd_addr       = idx_q;
    mark_we       = 1'b0;
    mark_wdata    = MARK_ABSENT;
    data_we       = 1'b0;
    data_zero_val = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        mark_we = 1'b1;
        idx_d   = idx_q + 1'b1;
        if (&idx_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_d = S_HASH1;
        end
      end
      S_HASH1: begin
        hash_d   = xorshift(key_q, 16) * HashMulA;
        status_d = STATUS_NOT_FOUND;
        found_d  = MARK_ABSENT;
        vout_d   = '0;
        state_d  = S_HASH2;
        if (kind_q == KIND_INSERT && occ_q >= max_entries_q) begin
          status_d = STATUS_FULL;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else if (kind_q != KIND_LOOKUP && kind_q != KIND_INSERT && kind_q != KIND_KILL) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_HASH2: begin
        hash_d  = xorshift(hash_q, 13) * HashMulB;
        state_d = S_HASH3;
      end
      S_HASH3: begin
        rd_en       = 1'b1;
        rd_addr     = home_idx;
        idx_d       = home_idx;
        probe_cnt_d = '0;
        state_d     = S_PROBE;
      end
      S_PROBE: begin
        // Every branch either finishes the command or moves to the next slot.
        logic step;
        step = 1'b0;
        unique case (kind_q)
          KIND_LOOKUP: begin
            if (mark_rd == MARK_ABSENT) begin
              status_d = STATUS_NOT_FOUND;
              done_d   = 1'b1;
            end else if (key_hit) begin
              status_d = STATUS_OK;
              found_d  = mark_rdata;
              vout_d   = val_rd32;
              done_d   = 1'b1;
            end else begin
              step = 1'b1;
            end
          end
          KIND_INSERT: begin
            if (mark_rd == MARK_ABSENT) begin
              mark_we    = 1'b1;
              mark_wdata = MARK_ACTIVE;
              data_we    = 1'b1;
              occ_d      = occ_q + 1'b1;
              status_d   = STATUS_OK;
              done_d     = 1'b1;
            end else if (key_hit) begin
              if (mark_rd == MARK_ACTIVE) begin
                status_d = STATUS_DUPLICATE;
              end else begin
                mark_we    = 1'b1;
                mark_wdata = MARK_ACTIVE;
                data_we    = 1'b1;
                status_d   = STATUS_OK;
              end
              done_d = 1'b1;
            end else begin
              step = 1'b1;
            end
          end
          KIND_KILL: begin
            if (mark_rd == MARK_ABSENT) begin
              status_d = STATUS_NO_ACTIVE;
              done_d   = 1'b1;
            end else if (key_hit && mark_rd == MARK_ACTIVE) begin
              mark_we       = 1'b1;
              mark_wdata    = MARK_TOMB;
              data_we       = 1'b1;
              data_zero_val = 1'b1;
              status_d      = STATUS_OK;
              done_d        = 1'b1;
            end else begin
              step = 1'b1;
            end
          end
          default: begin
            done_d = 1'b1;
          end
        endcase
        if (step) begin
          if (last_probe) begin
            // The whole table was visited without an answer.
            unique case (kind_q)
              KIND_INSERT: status_d = STATUS_FULL;
              KIND_KILL:   status_d = STATUS_NO_ACTIVE;
              default:     status_d = STATUS_NOT_FOUND;
            endcase
            done_d = 1'b1;
          end else begin
            rd_en       = 1'b1;
            rd_addr     = idx_q + 1'b1;
            idx_d       = idx_q + 1'b1;
            probe_cnt_d = probe_cnt_q + 1'b1;
          end
        end
        if (done_d) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      idx_q         <= '0;
      occ_q         <= '0;
      max_entries_q <= MaxEntriesReset;
      done_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      occ_q   <= occ_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_entries_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      kind_q  <= kind_e'(kind_i);
      key_q   <= key_i;
      value_q <= value_in_i;
    end
    hash_q      <= hash_d;
    probe_cnt_q <= probe_cnt_d;
    status_q    <= status_d;
    found_q     <= found_d;
    vout_q      <= vout_d;
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_state_o = found_q;
  assign value_out_o   = vout_q;

  tsht_ram #(
    .WIDTH (2),
    .DEPTH (SLOT_COUNT)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (idx_q),
    .wdata_i (mark_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (mark_rdata)
  );

  tsht_ram #(
    .WIDTH (DataBits),
    .DEPTH (SLOT_COUNT)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (idx_q),
    .wdata_i (data_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (data_rdata)
  );

endmodule
